@@ design/integer_to_radix_ascii_macros.svh @@
// assertion macros for the integer to radix ascii block
// no dependencies; included by the files that carry assertions
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ITRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ITRA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define ITRA_ASSERT(lbl, prop, msg)
`define ITRA_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/itra_pkg.sv @@
// constants and helpers for the integer to radix ascii block
// no dependencies
package itra_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int EXT_W       = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;
    localparam int DIG_W       = 6;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 2);
    localparam int IDX_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [CHAR_W-1:0]  CH_MINUS  = 7'h2D;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_ALPHA  = 7'h41;
    localparam logic [CHAR_W-1:0]  CH_NONE   = 7'h00;
    localparam logic [DIG_W-1:0]   DIG_NINE  = 6'd9;
    localparam logic [DIG_W-1:0]   DIG_TEN   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d > DIG_NINE) begin
            ch = CH_ALPHA + CHAR_W'(d - DIG_TEN);
        end else begin
            ch = CH_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction
endpackage

@@ design/integer_to_radix_ascii.sv @@
// integer to radix ascii converter, top level
// depends on itra_pkg and integer_to_radix_ascii_macros.svh
//
// usage
// - input channel i_valid / o_ready carries one request: value bits, signed flag
//   and radix; o_ready is high only while the converter is idle
// - output channel o_valid / i_ready carries one character per transfer, most
//   significant first, with a last flag and the total length on every character
// - a negative signed value gives a leading '-' and then its magnitude
// - a radix outside 2..36 gives one character of 0 with bad_radix and last set
// - the value bits are shifted in one per cycle into a row of radix digit lanes
//   (double and add the bit, with a generate/propagate carry across the lanes),
//   then leading zero digits are shifted out one per cycle, then one character
//   per cycle leaves through the output register while the receiver takes them
// - a stalled receiver holds the character in the output register and the
//   sequencer waits for it
// - the next request is taken as soon as the last character is in the output
//   register, even while it is still waiting to be taken
// - synchronous reset clears the sequencer and drops o_valid
`include "integer_to_radix_ascii_macros.svh"
module integer_to_radix_ascii (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [itra_pkg::IN_W-1:0]      i_value_bits,
    input  logic                           i_is_signed,
    input  logic [itra_pkg::RADIX_W-1:0]   i_radix,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [itra_pkg::CHAR_W-1:0]    o_text_char,
    output logic                           o_last_char,
    output logic                           o_bad_radix,
    output logic [itra_pkg::LEN_W-1:0]     o_text_length
);
    import itra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BAD, S_CONV, S_ALIGN, S_SIGN, S_EMIT
    } t_state;

    t_state                   r_state;
    logic [VALUE_WIDTH-1:0]   r_val;
    logic                     r_neg;
    logic [RADIX_W-1:0]       r_radix;
    logic [DIG_W-1:0]         r_dig [VALUE_WIDTH];
    logic [CNT_W-1:0]         r_ndig;
    logic [CNT_W-1:0]         r_cnt;
    logic [LEN_W-1:0]         r_len;

    logic                     r_out_valid;
    logic [CHAR_W-1:0]        r_out_char;
    logic                     r_out_last;
    logic                     r_out_bad;
    logic [LEN_W-1:0]         r_out_len;

    logic [EXT_W-1:0]         w_ext;
    logic [VALUE_WIDTH-1:0]   w_val;
    logic                     w_neg;
    logic [VALUE_WIDTH-1:0]   w_mag;
    logic                     w_bad;
    logic                     w_load;
    logic                     w_fill;
    logic [VALUE_WIDTH-1:0]   w_gen;
    logic [VALUE_WIDTH-1:0]   w_prop;
    logic [VALUE_WIDTH-1:0]   w_any;
    logic [VALUE_WIDTH:0]     w_sum;
    logic [VALUE_WIDTH:0]     w_cv;
    logic [DIG_W:0]           w_twice [VALUE_WIDTH];
    logic [DIG_W-1:0]         w_dig_conv [VALUE_WIDTH];
    logic [CNT_W-1:0]         n_ndig;

    // input decode
    always_comb begin
        w_ext = EXT_W'(i_value_bits);
        w_val = w_ext[VALUE_WIDTH-1:0];
        w_neg = i_is_signed & w_val[VALUE_WIDTH-1];
        w_mag = w_neg ? (VALUE_WIDTH'(0) - w_val) : w_val;
        w_bad = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    end

    // digit lanes: each digit becomes 2 * d + carry in, minus radix on carry out
    always_comb begin
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            w_gen[i]  = ({r_dig[i], 1'b0} >= {1'b0, r_radix});
            w_prop[i] = ({r_dig[i], 1'b1} == {1'b0, r_radix});
        end
        w_any = w_gen | w_prop;
        w_sum = {1'b0, w_any} + {1'b0, w_gen} + (VALUE_WIDTH + 1)'(r_val[VALUE_WIDTH-1]);
        w_cv  = w_sum ^ {1'b0, w_any} ^ {1'b0, w_gen};
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            w_twice[i] = {r_dig[i], w_cv[i]};
            w_dig_conv[i] = w_cv[i+1] ? DIG_W'(w_twice[i] - {1'b0, r_radix})
                                      : DIG_W'(w_twice[i]);
        end
        n_ndig = r_ndig + CNT_W'(w_cv[r_ndig[IDX_W-1:0]]);
    end

    assign w_load = !r_out_valid || i_ready;
    assign w_fill = w_load && ((r_state == S_BAD) || (r_state == S_SIGN) ||
                               (r_state == S_EMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ndig      <= CNT_W'(1);
            r_cnt       <= '0;
        end else begin
            r_out_valid <= w_fill || (r_out_valid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_radix <= i_radix;
                        r_neg   <= w_neg;
                        r_val   <= w_mag;
                        r_ndig  <= CNT_W'(1);
                        r_cnt   <= CNT_W'(VALUE_WIDTH);
                        for (int i = 0; i < VALUE_WIDTH; i++) begin
                            r_dig[i] <= '0;
                        end
                        r_state <= w_bad ? S_BAD : S_CONV;
                    end
                end
                S_BAD: begin
                    if (w_load) begin
                        r_out_char  <= CH_NONE;
                        r_out_last  <= 1'b1;
                        r_out_bad   <= 1'b1;
                        r_out_len   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_CONV: begin
                    r_val  <= r_val << 1;
                    r_ndig <= n_ndig;
                    for (int i = 0; i < VALUE_WIDTH; i++) begin
                        r_dig[i] <= w_dig_conv[i];
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        r_cnt   <= CNT_W'(VALUE_WIDTH) - n_ndig;
                        r_len   <= LEN_W'(n_ndig) + LEN_W'(r_neg);
                        r_state <= S_ALIGN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_ALIGN: begin
                    // drop leading zero digits off the top
                    if (r_cnt == '0) begin
                        r_cnt   <= r_ndig;
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        for (int i = VALUE_WIDTH - 1; i > 0; i--) begin
                            r_dig[i] <= r_dig[i-1];
                        end
                        r_dig[0] <= '0;
                        r_cnt    <= r_cnt - CNT_W'(1);
                    end
                end
                S_SIGN: begin
                    if (w_load) begin
                        r_out_char  <= CH_MINUS;
                        r_out_last  <= 1'b0;
                        r_out_bad   <= 1'b0;
                        r_out_len   <= r_len;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_char  <= digit_char(r_dig[VALUE_WIDTH-1]);
                        r_out_last  <= (r_cnt == CNT_W'(1));
                        r_out_bad   <= 1'b0;
                        r_out_len   <= r_len;
                        for (int i = VALUE_WIDTH - 1; i > 0; i--) begin
                            r_dig[i] <= r_dig[i-1];
                        end
                        r_dig[0] <= '0;
                        r_cnt    <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_text_char   = r_out_char;
    assign o_last_char   = r_out_last;
    assign o_bad_radix   = r_out_bad;
    assign o_text_length = r_out_len;

    `ITRA_NEVER(a_emit_count, (r_state == S_EMIT) && (r_cnt == '0), "emit with no digits left")
    `ITRA_NEVER(a_ndig_range, (r_ndig == '0) || (r_ndig > CNT_W'(VALUE_WIDTH)), "digit count out of range")
    `ITRA_ASSERT(a_bad_result, (o_valid && o_bad_radix) |-> (o_last_char && (o_text_char == CH_NONE)), "bad radix result malformed")
    `ITRA_ASSERT(a_good_start, (i_valid && o_ready && !w_bad) |=> (r_state == S_CONV), "good request did not start conversion")
    `ITRA_ASSERT(a_length_set, (o_valid && !o_bad_radix) |-> (o_text_length != '0), "character without length")
endmodule

@@ test/radix_text_checker.sv @@
// checker for the integer to radix ascii block: watches both channels,
// predicts the text of every request and compares each character
// depends on itra_pkg
`timescale 1ns / 1ps

module radix_text_checker
    import itra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [IN_W-1:0]    i_value_bits,
    input  logic               i_is_signed,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic               i_char_valid,
    input  logic               i_char_ready,
    input  logic [CHAR_W-1:0]  i_text_char,
    input  logic               i_last_char,
    input  logic               i_bad_radix,
    input  logic [LEN_W-1:0]   i_text_length,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
        logic [LEN_W-1:0]  len;
    } t_text_result;

    localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;

    t_text_result expected_q[$];
    t_text_result want;
    t_text_result got;
    int           char_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void predict_text(input logic [IN_W-1:0] bits,
                                         input logic sgn,
                                         input logic [RADIX_W-1:0] radix);
        logic [63:0]      mag;
        logic [63:0]      base;
        logic             neg;
        logic [DIG_W-1:0] digit_buf [0:63];
        logic [DIG_W-1:0] d;
        int               nd;
        int               total;
        t_text_result     res;
        mag  = 64'(bits) & VALUE_MASK;
        base = 64'(radix);
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            res.ch   = CH_NONE;
            res.last = 1'b1;
            res.bad  = 1'b1;
            res.len  = '0;
            expected_q.push_back(res);
            return;
        end
        neg = sgn && mag[VALUE_WIDTH-1];
        if (neg) begin
            mag = (64'd0 - mag) & VALUE_MASK;
        end
        nd = 0;
        do begin
            digit_buf[nd] = DIG_W'(mag % base);
            nd++;
            mag = mag / base;
        end while (mag != 64'd0);
        total = nd + (neg ? 1 : 0);
        res.bad = 1'b0;
        res.len = LEN_W'(total);
        if (neg) begin
            res.ch   = CH_MINUS;
            res.last = (total == 1);
            expected_q.push_back(res);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            d = digit_buf[i];
            res.ch   = (d > DIG_NINE) ? CH_ALPHA + CHAR_W'(d - DIG_TEN) : CH_ZERO + CHAR_W'(d);
            res.last = (i == 0);
            expected_q.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count = 0;
            char_count   = 0;
        end else begin
            if (i_char_valid && i_char_ready) begin
                got.ch   = i_text_char;
                got.last = i_last_char;
                got.bad  = i_bad_radix;
                got.len  = i_text_length;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("character %0d arrived with none expected (%0h)",
                                              char_count, got));
                end else begin
                    want = expected_q.pop_front();
                    if (got.ch !== want.ch)
                        report_mismatch($sformatf("character %0d: text_char %0h, expected %0h",
                                                  char_count, got.ch, want.ch));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("character %0d: last_char %0b, expected %0b",
                                                  char_count, got.last, want.last));
                    if (got.bad !== want.bad)
                        report_mismatch($sformatf("character %0d: bad_radix %0b, expected %0b",
                                                  char_count, got.bad, want.bad));
                    if (got.len !== want.len)
                        report_mismatch($sformatf("character %0d: text_length %0d, expected %0d",
                                                  char_count, got.len, want.len));
                end
                char_count++;
            end
            if (i_req_valid && i_req_ready) begin
                predict_text(i_value_bits, i_is_signed, i_radix);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

@@ test/tb_integer_to_radix_ascii.sv @@
// testbench top for the integer to radix ascii block: drives requests and
// the character sink, and gives the verdict from the checker's count
// depends on itra_pkg, integer_to_radix_ascii and radix_text_checker
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;
    import itra_pkg::*;

    localparam int CYCLE_LIMIT = 900_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 2 * VALUE_WIDTH + 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [IN_W-1:0]    i_value_bits = '0;
    logic               i_is_signed = 1'b0;
    logic [RADIX_W-1:0] i_radix = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [CHAR_W-1:0]  o_text_char;
    logic               o_last_char;
    logic               o_bad_radix;
    logic [LEN_W-1:0]   o_text_length;

    int fail_count;
    int pending;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_off = 1'b0;

    always #6 i_clk = ~i_clk;

    integer_to_radix_ascii i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value_bits  (i_value_bits),
        .i_is_signed   (i_is_signed),
        .i_radix       (i_radix),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char),
        .o_bad_radix   (o_bad_radix),
        .o_text_length (o_text_length)
    );

    radix_text_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_value_bits  (i_value_bits),
        .i_is_signed   (i_is_signed),
        .i_radix       (i_radix),
        .i_char_valid  (o_valid),
        .i_char_ready  (i_ready),
        .i_text_char   (o_text_char),
        .i_last_char   (o_last_char),
        .i_bad_radix   (o_bad_radix),
        .i_text_length (o_text_length),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    task automatic send_request(input logic [IN_W-1:0] req_value, input logic req_signed,
                                input logic [RADIX_W-1:0] req_radix);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value_bits <= req_value;
        i_is_signed  <= req_signed;
        i_radix      <= req_radix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [IN_W-1:0]    v;
        logic [RADIX_W-1:0] r;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 5))
                0: v = IN_W'($urandom_range(0, 40));
                1: v = '1 - IN_W'($urandom_range(0, 40));
                2: v = {1'b1, {(IN_W-1){1'b0}}} + IN_W'($urandom_range(0, 40));
                3: v = $urandom >> $urandom_range(0, 31);
                default: v = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                r = RADIX_W'($urandom_range(0, 63));
            end else begin
                r = RADIX_W'($urandom_range(2, 36));
            end
            send_request(v, 1'($urandom_range(0, 1)), r);
        end
    endtask

    // character sink
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(32'd0, 1'b0, 6'd10);
        send_request(32'd0, 1'b1, 6'd2);
        send_request(32'd1, 1'b0, 6'd2);
        send_request(32'hFFFF_FFFF, 1'b0, 6'd2);
        send_request(32'hFFFF_FFFF, 1'b1, 6'd10);
        send_request(32'hFFFF_FFFF, 1'b0, 6'd36);
        send_request(32'hFFFF_FFFF, 1'b0, 6'd3);
        send_request(32'h8000_0000, 1'b1, 6'd2);
        send_request(32'h8000_0000, 1'b1, 6'd36);
        send_request(32'h8000_0000, 1'b0, 6'd16);
        send_request(32'h7FFF_FFFF, 1'b1, 6'd36);
        send_request(32'h7FFF_FFFF, 1'b1, 6'd2);
        send_request(32'd35, 1'b0, 6'd36);
        send_request(32'd10, 1'b0, 6'd11);
        send_request(32'd9, 1'b1, 6'd10);
        send_request(32'hFFFF_FFF6, 1'b1, 6'd16);
        send_request(32'd12345, 1'b1, 6'd8);
        send_request(32'hDEAD_BEEF, 1'b0, 6'd0);
        send_request(32'h8000_0000, 1'b1, 6'd1);
        send_request(32'd42, 1'b0, 6'd37);
        send_request(32'hFFFF_FFFF, 1'b1, 6'd63);
        wait_for_drain();

        send_random(120);
        wait_for_drain();

        // no idling on either side
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(60);

        // sink holds off while requests keep coming
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        hold_off = 1'b1;
        send_random(40);
        wait_for_drain();

        send_random(130);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
